// ===== src/bdth_pkg.sv =====
// package: shared types and constants for the button debounce tap/hold unit
`timescale 1ns / 1ps

package bdth_pkg;

  // width of a timing register as written through the configuration port
  localparam int unsigned REG_W = 24;
  // width of the configuration register index
  localparam int unsigned CFG_IDX_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS     = CFG_IDX_W'(1);

  // register reset values
  localparam logic [REG_W-1:0] DEBOUNCE_TICKS_RST = REG_W'(33);
  localparam logic [REG_W-1:0] HOLD_TICKS_RST     = REG_W'(2000);

  // event codes on the result channel
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_TAP    = 2'd1,
    EV_SELECT = 2'd2
  } event_e;

  typedef struct packed {
    logic button_level;
  } in_item_t;

  typedef struct packed {
    event_e event_code;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [REG_W-1:0]     data;
  } cfg_req_t;

endpackage

// ===== src/bdth_chan_if.sv =====
// interface: valid/ready channel carrying one payload per request
`timescale 1ns / 1ps

interface bdth_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/button_debounce_tap_hold_unit.sv =====
// top level: debounces a sampled button and reports tap and long-hold select events
//
//   channel  dir  payload                      request when
//   in_i     in   button_level (1 bit)         in_i.valid && in_i.ready
//   out_o    out  event_code (2 bit)           out_o.valid && out_o.ready
//   cfg_i    in   index (8 bit), data (24 bit) cfg_i.valid && cfg_i.ready
//
// one sample is taken per cycle while the output register is not stalled;
// its event appears in the output register on the next cycle
// the output register is the only buffer: a sample is taken whenever it is
// empty or being drained in the same cycle
// rst_ni clears the phase, the countdown, the flags and the output valid,
// and restores the timing registers to 33 and 2000 ticks
// configuration writes are always taken, as cfg_i.ready is tied high
`timescale 1ns / 1ps

module button_debounce_tap_hold_unit
  import bdth_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bdth_chan_if.sink   in_i,
  bdth_chan_if.source out_o,
  bdth_chan_if.sink   cfg_i
);

  // phase codes
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [1:0] PH_HOLD     = 2'd2;

  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  // timing registers
  logic [REG_W-1:0] debounce_ticks_q;
  logic [REG_W-1:0] hold_ticks_q;

  // tracking state
  logic                   last_level_q, last_level_d;
  logic                   hold_selected_q, hold_selected_d;
  logic [1:0]             phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] countdown_q, countdown_d;

  // output register
  logic   out_valid_q, out_valid_d;
  event_e out_event_q;
  event_e event_d;

  logic in_take;
  logic level;

  // register value to counter load, saturating when the counter is narrower
  function automatic logic [COUNT_WIDTH-1:0] load_value(input logic [REG_W-1:0] r);
    logic [COUNT_WIDTH-1:0] v;
    if (COUNT_WIDTH >= REG_W) begin
      v = COUNT_WIDTH'(r);
    end else if ((r >> COUNT_WIDTH) != '0) begin
      v = '1;
    end else begin
      v = COUNT_WIDTH'(r);
    end
    return v;
  endfunction

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= DEBOUNCE_TICKS_RST;
      hold_ticks_q     <= HOLD_TICKS_RST;
    end else if (cfg_i.valid) begin
      // writes to indexes outside the register list are dropped
      if (cfg_i.data.index == REG_DEBOUNCE_TICKS) begin
        debounce_ticks_q <= cfg_i.data.data;
      end else if (cfg_i.data.index == REG_HOLD_TICKS) begin
        hold_ticks_q <= cfg_i.data.data;
      end
    end
  end

  // take a sample when the output register is free or draining
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_take    = in_i.valid && in_i.ready;
  assign level      = in_i.data.button_level;

  always_comb begin
    last_level_d    = last_level_q;
    hold_selected_d = hold_selected_q;
    phase_d         = phase_q;
    countdown_d     = countdown_q;
    event_d         = EV_NONE;

    if (level != last_level_q) begin
      // any edge restarts debounce; a press forgets an earlier select
      last_level_d = level;
      if (level) begin
        hold_selected_d = 1'b0;
      end
      phase_d     = PH_DEBOUNCE;
      countdown_d = load_value(debounce_ticks_q);
    end else if (phase_q == PH_DEBOUNCE || phase_q == PH_HOLD) begin
      if (countdown_q > CNT_ONE) begin
        countdown_d = countdown_q - CNT_ONE;
      end else if (phase_q == PH_DEBOUNCE) begin
        if (level) begin
          // stable press: start timing the hold
          phase_d     = PH_HOLD;
          countdown_d = load_value(hold_ticks_q);
        end else begin
          // stable release: a tap unless the press already became a select
          phase_d     = PH_IDLE;
          countdown_d = '0;
          if (!hold_selected_q) begin
            event_d = EV_TAP;
          end
        end
      end else begin
        // hold time reached
        phase_d         = PH_IDLE;
        countdown_d     = '0;
        hold_selected_d = 1'b1;
        event_d         = EV_SELECT;
      end
    end else begin
      phase_d = PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q    <= 1'b0;
      hold_selected_q <= 1'b0;
      phase_q         <= PH_IDLE;
      countdown_q     <= '0;
    end else if (in_take) begin
      last_level_q    <= last_level_d;
      hold_selected_q <= hold_selected_d;
      phase_q         <= phase_d;
      countdown_q     <= countdown_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_take) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      out_event_q <= event_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.data.event_code = out_event_q;

endmodule
